[src/streaming_block_average_error_macros.svh]
// Assertion macros for the block averager.
`ifndef STREAMING_BLOCK_AVERAGE_ERROR_MACROS_SVH
`define STREAMING_BLOCK_AVERAGE_ERROR_MACROS_SVH
`ifndef SYNTHESIS
`define SBAE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define SBAE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SBAE_ASSERT(lbl, clk, rstn, prop)
`define SBAE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[src/sbae_pkg.sv]
// Types and constants shared by the block averager files.
`default_nettype none
package sbae_pkg;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam logic [12:0] MAX_BLOCK_LEN = 13'd4096;
  localparam logic [16:0] MAX_BLOCKS = 17'd65536;
  localparam logic [46:0] VAR_LIMIT = '1;

  localparam logic [1:0] ACT_DEPOSIT = 2'd0;
  localparam logic [1:0] ACT_REPORT = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] STAT_NONE = 2'd0;
  localparam logic [1:0] STAT_PARTIAL = 2'd1;
  localparam logic [1:0] STAT_ONE = 2'd2;
  localparam logic [1:0] STAT_FULL = 2'd3;

  localparam logic [6:0] DIV_STEPS = 7'd96;
  localparam logic [6:0] MUL_STEPS = 7'd64;
  localparam logic [6:0] SQRT_STEPS = 7'd32;
  localparam logic [63:0] SQRT_TOP = 64'h4000_0000_0000_0000;

  typedef enum logic [1:0] {
    UOP_DIV,
    UOP_MUL,
    UOP_SQRT
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_BM_DIV,
    ST_BM_MUL,
    ST_RM_DIV,
    ST_RE_SQ,
    ST_RE_NN,
    ST_RE_NSQ,
    ST_RE_DIV,
    ST_RE_SQRT,
    ST_RV_T,
    ST_RV_TSQ,
    ST_RV_DIV,
    ST_RESP
  } state_e;
endpackage
`default_nettype wire

[src/sbae_if.sv]
// Stream channel interfaces for samples in and statistics out.
`default_nettype none
interface sbae_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] sample;
  modport source (output valid, output action, output sample, input ready);
  modport sink (input valid, input action, input sample, output ready);
endinterface

interface sbae_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] mean;
  logic [31:0] mean_error;
  logic [46:0] variance;
  logic [1:0]  status;
  logic [16:0] blocks_done;
  logic        overflow;
  modport source (output valid, output mean, output mean_error, output variance,
                  output status, output blocks_done, output overflow, input ready);
  modport sink (input valid, input mean, input mean_error, input variance,
                input status, input blocks_done, input overflow, output ready);
endinterface
`default_nettype wire

[src/sbae_iter_unit.sv]
// Shared iterative divide, multiply and square root unit.
`default_nettype none
module sbae_iter_unit import sbae_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  unit_req_t   req_i,
  input  logic [95:0] a_i,
  input  logic [63:0] b_i,
  output unit_sts_t   sts_o,
  output logic [95:0] res_o
);
  logic        busy_q, busy_d, done_q, done_d;
  unit_op_e    op_q, op_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [95:0] w_q, w_d;
  logic [64:0] v_q, v_d;
  logic [63:0] u_q, u_d;
  logic [64:0] rs, st;

  always_comb begin
    rs = {v_q[63:0], w_q[95]};
    st = {1'b0, v_q[63:0]} + {1'b0, u_q};
    busy_d = busy_q;
    done_d = 1'b0;
    op_d = op_q;
    cnt_d = cnt_q;
    w_d = w_q;
    v_d = v_q;
    u_d = u_q;
    if (req_i.start) begin
      op_d = req_i.op;
      busy_d = 1'b1;
      unique case (req_i.op)
        UOP_DIV: begin
          w_d = a_i;
          v_d = '0;
          u_d = b_i;
          cnt_d = DIV_STEPS - 7'd1;
        end
        UOP_MUL: begin
          w_d = '0;
          v_d = {1'b0, b_i};
          u_d = a_i[63:0];
          cnt_d = MUL_STEPS - 7'd1;
        end
        UOP_SQRT: begin
          w_d = {32'd0, a_i[63:0]};
          v_d = '0;
          u_d = SQRT_TOP;
          cnt_d = SQRT_STEPS - 7'd1;
        end
        default: busy_d = 1'b0;
      endcase
    end else if (busy_q) begin
      unique case (op_q)
        UOP_DIV: begin
          w_d = {w_q[94:0], 1'b0};
          if (rs >= {1'b0, u_q}) begin
            v_d = rs - {1'b0, u_q};
            w_d[0] = 1'b1;
          end else begin
            v_d = rs;
          end
        end
        UOP_MUL: begin
          w_d = {w_q[94:0], 1'b0} + (v_q[63] ? {32'd0, u_q} : 96'd0);
          v_d = {v_q[63:0], 1'b0};
        end
        UOP_SQRT: begin
          if ({1'b0, w_q[63:0]} >= st) begin
            w_d = {32'd0, w_q[63:0] - st[63:0]};
            v_d = {1'b0, v_q[64:1]} + {1'b0, u_q};
          end else begin
            v_d = {1'b0, v_q[64:1]};
          end
          u_d = {2'b00, u_q[63:2]};
        end
        default: ;
      endcase
      if (cnt_q == 7'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q <= UOP_DIV;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q <= op_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    v_q <= v_d;
    u_q <= u_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign res_o = (op_q == UOP_SQRT) ? {32'd0, v_q[63:0]} : w_q;
endmodule
`default_nettype wire

[src/streaming_block_average_error.sv]
// Streaming block averager with standard error of the mean.
// Usage:
//   in_i carries beats of action and sample: deposit, report or clear.
//   out_o carries one beat per report: mean, error, variance, status,
//   completed block count and drop flag.
//   cfg_we_i/cfg_data_i write the block length and restart all sums.
// Sequencing:
//   A deposit, clear or unused action passes through the decide state back to idle.
//   A deposit that closes a block also runs one 96-step divide
//   and one 64-step multiply on the shared iterative unit, each with an
//   issue and a handoff.
//   A report with no data goes straight to the response; one with at most
//   one block runs one divide, and one with two or more blocks runs three
//   divides, five multiplies and one 32-step root, all on that unit.
//   in_i.ready is high only while the sequencer is idle.
// Reset clears all sums and held results; block length returns to 1.
// A stalled receiver holds the result beat in the output register; the
// block keeps taking beats and waits only to place the next result.
`default_nettype none
`include "streaming_block_average_error_macros.svh"
module streaming_block_average_error import sbae_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire   [12:0] cfg_data_i,
  sbae_in_if.sink      in_i,
  sbae_out_if.source   out_o
);
  state_e             state_q, state_d;
  logic               issued_q, issued_d;
  logic [12:0]        spb_q, spb_d;
  logic [1:0]         act_q, act_d;
  logic signed [15:0] smp_q, smp_d;
  logic [12:0]        fill_q, fill_d;
  logic [16:0]        bc_q, bc_d;
  logic signed [27:0] bsum_q, bsum_d;
  logic [43:0]        sqs_q, sqs_d;
  logic signed [48:0] bmt_q, bmt_d;
  logic [63:0]        bmst_q, bmst_d;
  logic [59:0]        sst_q, sst_d;
  logic [31:0]        hmean_q, hmean_d;
  logic [31:0]        herr_q, herr_d;
  logic [46:0]        hvar_q, hvar_d;
  logic               drop_q, drop_d;
  logic               neg_q, neg_d;
  logic [63:0]        sq_q, sq_d;
  logic [63:0]        dv_q, dv_d;
  logic [1:0]         stat_q, stat_d;
  logic               ovalid_q, ovalid_d;

  unit_req_t          ureq;
  unit_sts_t          usts;
  logic [95:0]        ua, ures;
  logic [63:0]        ub;
  logic               op_state, op_done;

  logic [12:0]        blen;
  logic signed [27:0] bsum_new;
  logic signed [31:0] smp_sq;
  logic [12:0]        fill_new;
  logic [27:0]        bsum_mag;
  logic [48:0]        bmt_mag;
  logic [31:0]        q_signed;
  logic [95:0]        enum_num, vnum_num, e_diff, v_diff;
  logic               load_out;

  sbae_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .a_i    (ua),
    .b_i    (ub),
    .sts_o  (usts),
    .res_o  (ures)
  );

  always_comb begin
    if (spb_q == 13'd0) blen = 13'd1;
    else if (spb_q > MAX_BLOCK_LEN) blen = MAX_BLOCK_LEN;
    else blen = spb_q;
    smp_sq = smp_q * smp_q;
    bsum_new = bsum_q + 28'(smp_q);
    fill_new = fill_q + 13'd1;
    bsum_mag = bsum_q[27] ? 28'(-bsum_q) : 28'(bsum_q);
    bmt_mag = bmt_q[48] ? 49'(-bmt_q) : 49'(bmt_q);
    q_signed = neg_q ? -ures[31:0] : ures[31:0];
    enum_num = {16'd0, bmst_q, 16'd0};
    vnum_num = {4'd0, sst_q, 32'd0};
    e_diff = (ures > enum_num) ? 96'd0 : enum_num - ures;
    v_diff = (ures > vnum_num) ? 96'd0 : vnum_num - ures;
    op_state = (state_q != ST_IDLE) && (state_q != ST_DECIDE) && (state_q != ST_RESP);
    op_done = issued_q && usts.done;
    load_out = (state_q == ST_RESP) && (!ovalid_q || out_o.ready);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_i.valid) state_d = ST_DECIDE;
      ST_DECIDE: begin
        unique case (act_q)
          ACT_DEPOSIT:
            if (bc_q < MAX_BLOCKS && fill_new >= blen) state_d = ST_BM_DIV;
            else state_d = ST_IDLE;
          ACT_REPORT:
            if (bc_q == 17'd0 && fill_q == 13'd0) state_d = ST_RESP;
            else state_d = ST_RM_DIV;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_BM_DIV: if (op_done) state_d = ST_BM_MUL;
      ST_BM_MUL: if (op_done) state_d = ST_IDLE;
      ST_RM_DIV: if (op_done) state_d = (bc_q > 17'd1) ? ST_RE_SQ : ST_RESP;
      ST_RE_SQ: if (op_done) state_d = ST_RE_NN;
      ST_RE_NN: if (op_done) state_d = ST_RE_NSQ;
      ST_RE_NSQ: if (op_done) state_d = ST_RE_DIV;
      ST_RE_DIV: if (op_done) state_d = ST_RE_SQRT;
      ST_RE_SQRT: if (op_done) state_d = ST_RV_T;
      ST_RV_T: if (op_done) state_d = ST_RV_TSQ;
      ST_RV_TSQ: if (op_done) state_d = ST_RV_DIV;
      ST_RV_DIV: if (op_done) state_d = ST_RESP;
      ST_RESP: if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    spb_d = spb_q;
    act_d = act_q;
    smp_d = smp_q;
    fill_d = fill_q;
    bc_d = bc_q;
    bsum_d = bsum_q;
    sqs_d = sqs_q;
    bmt_d = bmt_q;
    bmst_d = bmst_q;
    sst_d = sst_q;
    hmean_d = hmean_q;
    herr_d = herr_q;
    hvar_d = hvar_q;
    drop_d = drop_q;
    neg_d = neg_q;
    sq_d = sq_q;
    dv_d = dv_q;
    stat_d = stat_q;
    ovalid_d = ovalid_q && !out_o.ready;
    issued_d = op_state && !usts.done;
    ureq.start = op_state && !issued_q;
    ureq.op = UOP_MUL;
    ua = '0;
    ub = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          act_d = in_i.action;
          smp_d = in_i.sample;
        end
      end
      ST_DECIDE: begin
        unique case (act_q)
          ACT_DEPOSIT: begin
            if (bc_q >= MAX_BLOCKS) begin
              drop_d = 1'b1;
            end else begin
              bsum_d = bsum_new;
              sqs_d = sqs_q + 44'(unsigned'(smp_sq));
              fill_d = fill_new;
              neg_d = bsum_new[27];
            end
          end
          ACT_REPORT: begin
            if (bc_q == 17'd0) begin
              neg_d = bsum_q[27];
              stat_d = (fill_q == 13'd0) ? STAT_NONE : STAT_PARTIAL;
            end else begin
              neg_d = bmt_q[48];
              stat_d = (bc_q == 17'd1) ? STAT_ONE : STAT_FULL;
            end
          end
          ACT_CLEAR: begin
            fill_d = '0;
            bc_d = '0;
            bsum_d = '0;
            sqs_d = '0;
            bmt_d = '0;
            bmst_d = '0;
            sst_d = '0;
            drop_d = 1'b0;
          end
          default: ;
        endcase
      end
      ST_BM_DIV: begin
        ureq.op = UOP_DIV;
        ua = {52'd0, bsum_mag, 16'd0};
        ub = {51'd0, fill_q};
        if (op_done) begin
          sq_d = {32'd0, ures[31:0]};
          bmt_d = bmt_q + 49'(signed'(q_signed));
        end
      end
      ST_BM_MUL: begin
        ua = {32'd0, sq_q};
        ub = sq_q;
        if (op_done) begin
          bmst_d = bmst_q + {16'd0, ures[63:16]};
          sst_d = sst_q + {16'd0, sqs_q};
          bc_d = bc_q + 17'd1;
          bsum_d = '0;
          sqs_d = '0;
          fill_d = '0;
        end
      end
      ST_RM_DIV: begin
        ureq.op = UOP_DIV;
        if (bc_q == 17'd0) begin
          ua = {52'd0, bsum_mag, 16'd0};
          ub = {51'd0, fill_q};
        end else begin
          ua = {47'd0, bmt_mag};
          ub = {47'd0, bc_q};
        end
        if (op_done) begin
          hmean_d = q_signed;
          sq_d = {32'd0, ures[31:0]};
        end
      end
      ST_RE_SQ: begin
        ua = {32'd0, sq_q};
        ub = sq_q;
        if (op_done) sq_d = ures[63:0];
      end
      ST_RE_NN: begin
        ua = {79'd0, bc_q};
        ub = {47'd0, bc_q - 17'd1};
        if (op_done) dv_d = ures[63:0];
      end
      ST_RE_NSQ: begin
        ua = {32'd0, sq_q};
        ub = {47'd0, bc_q};
      end
      ST_RE_DIV: begin
        ureq.op = UOP_DIV;
        ua = e_diff;
        ub = dv_q;
      end
      ST_RE_SQRT: begin
        ureq.op = UOP_SQRT;
        ua = {32'd0, (ures[95:64] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : ures[63:0]};
        if (op_done) herr_d = ures[31:0];
      end
      ST_RV_T: begin
        ua = {79'd0, bc_q};
        ub = {51'd0, blen};
        if (op_done) dv_d = ures[63:0];
      end
      ST_RV_TSQ: begin
        ua = {32'd0, sq_q};
        ub = dv_q;
      end
      ST_RV_DIV: begin
        ureq.op = UOP_DIV;
        ua = v_diff;
        ub = dv_q - 64'd1;
        if (op_done) hvar_d = (ures[95:63] != 33'd0) ? VAR_LIMIT : ures[62:16];
      end
      ST_RESP: if (load_out) ovalid_d = 1'b1;
      default: ;
    endcase
    if (cfg_we_i) begin
      spb_d = cfg_data_i;
      fill_d = '0;
      bc_d = '0;
      bsum_d = '0;
      sqs_d = '0;
      bmt_d = '0;
      bmst_d = '0;
      sst_d = '0;
      drop_d = 1'b0;
      hmean_d = '0;
      herr_d = '0;
      hvar_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      issued_q <= 1'b0;
      ovalid_q <= 1'b0;
      spb_q <= 13'd1;
      fill_q <= '0;
      bc_q <= '0;
      bsum_q <= '0;
      sqs_q <= '0;
      bmt_q <= '0;
      bmst_q <= '0;
      sst_q <= '0;
      hmean_q <= '0;
      herr_q <= '0;
      hvar_q <= '0;
      drop_q <= 1'b0;
    end else begin
      state_q <= state_d;
      issued_q <= issued_d;
      ovalid_q <= ovalid_d;
      spb_q <= spb_d;
      fill_q <= fill_d;
      bc_q <= bc_d;
      bsum_q <= bsum_d;
      sqs_q <= sqs_d;
      bmt_q <= bmt_d;
      bmst_q <= bmst_d;
      sst_q <= sst_d;
      hmean_q <= hmean_d;
      herr_q <= herr_d;
      hvar_q <= hvar_d;
      drop_q <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    smp_q <= smp_d;
    neg_q <= neg_d;
    sq_q <= sq_d;
    dv_q <= dv_d;
    stat_q <= stat_d;
    if (load_out) begin
      out_o.mean <= hmean_q;
      out_o.mean_error <= herr_q;
      out_o.variance <= hvar_q;
      out_o.status <= stat_q;
      out_o.blocks_done <= bc_q;
      out_o.overflow <= drop_q;
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign out_o.valid = ovalid_q;

  `SBAE_ASSERT(a_start_busy, clk_i, rst_ni, ureq.start |-> op_state)
  `SBAE_ASSERT(a_ready_unit_idle, clk_i, rst_ni, in_i.ready |-> !usts.busy)
  `SBAE_ASSERT(a_out_from_resp, clk_i, rst_ni, $rose(ovalid_q) |-> $past(state_q) == ST_RESP)
  `SBAE_ASSERT_NEXT(a_done_advance, clk_i, rst_ni, op_done && state_q == ST_RV_DIV,
                    state_q == ST_RESP)
endmodule
`default_nettype wire

[dv/tb_streaming_block_average_error.sv]
// Self-checking testbench for the streaming block averager: predicts every report beat.
`default_nettype none
module tb_streaming_block_average_error;
  import sbae_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  action;
    logic [15:0] sample;
  } beat_t;

  typedef struct {
    logic [31:0] mean;
    logic [31:0] mean_error;
    logic [46:0] variance;
    logic [1:0]  status;
    logic [16:0] blocks_done;
    logic        overflow;
  } stats_t;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 250;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [12:0] cfg_data_i = '0;

  sbae_in_if  in_if ();
  sbae_out_if out_if ();

  streaming_block_average_error dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #6 clk_i = ~clk_i;

  beat_t  pending_beats[$];
  stats_t stats_expected[$];
  int     beats_sent = 0;
  int     beats_taken = 0;
  int     fail_count = 0;
  int     idle_cycles = 0;
  bit     calm = 1'b0;
  bit     long_hold_req = 1'b0;

  // predictor state
  logic [12:0] blk_cfg;
  int          fill_cnt;
  longint      blk_cnt;
  longint      blk_sum;
  logic [63:0] blk_sq_sum;
  longint      mean_total;
  logic [63:0] mean_sq_total;
  logic [63:0] sample_sq_total;
  longint      held_mean;
  logic [63:0] held_err;
  logic [46:0] held_var;
  bit          dropped;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] r, b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint eff_len();
    if (blk_cfg == 0) return 1;
    if (blk_cfg > MAX_BLOCK_LEN) return longint'(MAX_BLOCK_LEN);
    return longint'(blk_cfg);
  endfunction

  task automatic clear_sums();
    fill_cnt = 0;
    blk_cnt = 0;
    blk_sum = 0;
    blk_sq_sum = '0;
    mean_total = 0;
    mean_sq_total = '0;
    sample_sq_total = '0;
    dropped = 1'b0;
  endtask

  task automatic restart_stats(logic [12:0] len);
    blk_cfg = len;
    clear_sums();
    held_mean = 0;
    held_err = '0;
    held_var = '0;
  endtask

  task automatic deposit_sample(logic [15:0] raw);
    longint      s, m;
    logic [63:0] am;
    s = longint'($signed(raw));
    if (blk_cnt >= longint'(MAX_BLOCKS)) begin
      dropped = 1'b1;
      return;
    end
    am = (s < 0) ? -s : s;
    blk_sum += s;
    blk_sq_sum += am * am;
    fill_cnt++;
    if (fill_cnt >= eff_len()) begin
      m = (blk_sum * 65536) / longint'(fill_cnt);
      am = (m < 0) ? -m : m;
      mean_total += m;
      mean_sq_total += (am * am) >> 16;
      sample_sq_total += blk_sq_sum;
      blk_cnt++;
      blk_sum = 0;
      blk_sq_sum = '0;
      fill_cnt = 0;
    end
  endtask

  task automatic report_stats();
    stats_t       res;
    logic [1:0]   st;
    logic [63:0]  n, am, sq, t;
    logic [127:0] num, sub, q;
    n = blk_cnt;
    if (n == 0) begin
      if (fill_cnt != 0) begin
        held_mean = (blk_sum * 65536) / longint'(fill_cnt);
        st = STAT_PARTIAL;
      end else begin
        st = STAT_NONE;
      end
    end else begin
      held_mean = mean_total / blk_cnt;
      st = STAT_ONE;
      if (n > 1) begin
        st = STAT_FULL;
        am = (held_mean < 0) ? -held_mean : held_mean;
        sq = am * am;
        num = {48'd0, mean_sq_total, 16'd0};
        sub = 128'(n) * 128'(sq);
        num = (num < sub) ? '0 : num - sub;
        q = num / 128'(n * (n - 1));
        held_err = floor_root(q[127:64] != 0 ? '1 : q[63:0]) & 64'hFFFF_FFFF;
        t = n * 64'(eff_len());
        num = {32'd0, sample_sq_total, 32'd0};
        sub = 128'(t) * 128'(sq);
        num = (num < sub) ? '0 : num - sub;
        q = num / 128'(t - 1);
        if (q[127:64] != 0 || (q[63:0] >> 16) > 64'(VAR_LIMIT)) held_var = VAR_LIMIT;
        else held_var = q[62:16];
      end
    end
    res.mean = held_mean[31:0];
    res.mean_error = held_err[31:0];
    res.variance = held_var;
    res.status = st;
    res.blocks_done = blk_cnt[16:0];
    res.overflow = dropped;
    stats_expected.insert(stats_expected.size(), res);
  endtask

  task automatic apply_beat(beat_t b);
    case (b.action)
      ACT_DEPOSIT: deposit_sample(b.sample);
      ACT_REPORT:  report_stats();
      ACT_CLEAR:   clear_sums();
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin
    beat_t b;
    int    gap;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        b.action = in_if.action;
        b.sample = in_if.sample;
        apply_beat(b);
        beats_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap > 0) begin
          gap--;
          in_if.valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          b = pending_beats.pop_front();
          beats_sent++;
          in_if.valid <= 1'b1;
          in_if.action <= b.action;
          in_if.sample <= b.sample;
          gap = pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    stats_t e;
    int     stall;
    int     long_left;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (stats_expected.size() == 0) begin
          $error("result beat with no report pending");
          fail_count++;
        end else begin
          e = stats_expected.pop_front();
          if (out_if.mean !== e.mean) begin
            $error("mean exp %0h got %0h", e.mean, out_if.mean);
            fail_count++;
          end
          if (out_if.mean_error !== e.mean_error) begin
            $error("mean_error exp %0h got %0h", e.mean_error, out_if.mean_error);
            fail_count++;
          end
          if (out_if.variance !== e.variance) begin
            $error("variance exp %0h got %0h", e.variance, out_if.variance);
            fail_count++;
          end
          if (out_if.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_if.status);
            fail_count++;
          end
          if (out_if.blocks_done !== e.blocks_done) begin
            $error("blocks_done exp %0d got %0d", e.blocks_done, out_if.blocks_done);
            fail_count++;
          end
          if (out_if.overflow !== e.overflow) begin
            $error("overflow exp %0d got %0d", e.overflow, out_if.overflow);
            fail_count++;
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        long_left = 1500;
      end
      if (long_left > 0) begin
        long_left--;
        out_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push(logic [1:0] act, logic [15:0] smp);
    beat_t b;
    b.action = act;
    b.sample = smp;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || beats_sent != beats_taken || stats_expected.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_len(logic [12:0] len);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= len;
    restart_stats(len);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 7)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_run(int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 78) push(ACT_DEPOSIT, rand_sample());
      else if (r < 92) push(ACT_REPORT, 16'($urandom));
      else if (r < 97) push(ACT_CLEAR, 16'($urandom));
      else push(2'd3, 16'($urandom));
    end
  endtask

  initial begin
    logic [12:0] lens[10];
    in_if.valid = 1'b0;
    in_if.action = ACT_DEPOSIT;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    restart_stats(13'd1);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: no data, extremes, clear, unused action, partial and single block
    push(ACT_REPORT, 16'h0000);
    push(ACT_DEPOSIT, 16'h7FFF);
    push(ACT_REPORT, 16'hFFFF);
    push(ACT_DEPOSIT, 16'h8000);
    push(ACT_REPORT, 16'h0000);
    push(ACT_DEPOSIT, 16'h8000);
    push(ACT_DEPOSIT, 16'h8000);
    push(ACT_REPORT, 16'h0000);
    push(2'd3, 16'h1234);
    push(ACT_CLEAR, 16'h0000);
    push(ACT_REPORT, 16'h0000);
    push(ACT_DEPOSIT, 16'h0001);
    push(ACT_DEPOSIT, 16'h0001);
    push(ACT_REPORT, 16'h0000);
    write_len(13'd3);
    push(ACT_DEPOSIT, 16'hFFFF);
    push(ACT_REPORT, 16'h0000);
    push(ACT_DEPOSIT, 16'h0002);
    push(ACT_DEPOSIT, 16'h0000);
    push(ACT_REPORT, 16'h0000);
    push(ACT_DEPOSIT, 16'h7FFF);
    push(ACT_DEPOSIT, 16'h7FFF);
    push(ACT_DEPOSIT, 16'h8000);
    push(ACT_REPORT, 16'h0000);

    // long receiver hold-off while reports pile up
    write_len(13'd2);
    long_hold_req = 1'b1;
    repeat (60) begin
      push(ACT_DEPOSIT, rand_sample());
      push(ACT_REPORT, 16'h0000);
    end

    // oversized length, partial blocks only
    write_len(13'h1FFF);
    repeat (30) push(ACT_DEPOSIT, rand_sample());
    push(ACT_REPORT, 16'h0000);

    write_len(13'd0);
    repeat (6) push(ACT_DEPOSIT, rand_sample());
    push(ACT_REPORT, 16'h0000);

    write_len(13'd4096);
    repeat (40) push(ACT_DEPOSIT, rand_sample());
    push(ACT_REPORT, 16'h0000);

    lens = '{13'd1, 13'd2, 13'd3, 13'd4, 13'd5, 13'd7, 13'd8, 13'd16, 13'd0, 13'd1};
    for (int p = 0; p < 12; p++) begin
      write_len(p < 10 ? lens[p] : 13'($urandom_range(1, 12)));
      calm = ($urandom_range(0, 3) == 0);
      random_run(125);
    end
    calm = 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+src
src/sbae_pkg.sv
src/sbae_if.sv
src/sbae_iter_unit.sv
src/streaming_block_average_error.sv
dv/tb_streaming_block_average_error.sv
